// File: hdl/pme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pme_pkg;

	// sizing of the engine
	localparam int MAX_NODES   = 32;
	localparam int MAX_EDGES   = 64;
	localparam int WEIGHT_BITS = 16;

	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int NCNT_W  = $clog2(MAX_NODES + 1);
	localparam int SLOT_W  = $clog2(MAX_EDGES);
	localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
	localparam int ENTRY_W = 2 * NODE_W + WEIGHT_BITS;

	// fixed field widths of the ports
	localparam int KIND_W    = 3;
	localparam int TOTAL_W   = 21;
	localparam int NCFG_W    = 6;
	localparam int ECFG_W    = 7;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_COUNT = 1'd1;

	// request types
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_START = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_EDGE         = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DONE         = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY        = 3'd2;
	localparam logic [KIND_W-1:0] KIND_START_MISS   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DISCONNECTED = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// File: hdl/pme_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/prim_mst_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Load request: no result; a load can be taken every cycle while the core is idle.
// Start request: each round scans the m live edge slots, one registered RAM read per cycle,
// and a run of k accepted edges takes k + 1 rounds plus output stalls, with in_ready low meanwhile.
// Empty graph and missing start give their single result from the finish state, without a scan.
// Reset clears control, configuration, tree marks and totals; the edge table is not cleared.

module prim_mst_engine_core
	import pme_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,

	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 req_type,
	input  wire logic [5:0]           edge_slot,
	input  wire logic [4:0]           end_a,
	input  wire logic [4:0]           end_b,
	input  wire logic signed [15:0]   edge_weight,
	input  wire logic [4:0]           start_node,

	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [KIND_W-1:0]         kind,
	output logic [5:0]                accepted_edge,
	output logic [4:0]                joined_node,
	output logic signed [TOTAL_W-1:0] total_weight,
	output logic                      last
);

	// configuration registers
	logic [NCFG_W-1:0] node_cfg_q;
	logic [ECFG_W-1:0] edge_cfg_q;

	// sequencer and tree state
	state_t                          state_q, state_nxt;
	logic [MAX_NODES-1:0]            marks_q;
	logic [NCNT_W-1:0]               size_q;
	logic signed [TOTAL_W-1:0]       total_q;
	logic [ECNT_W-1:0]               rd_idx_q;
	logic                            pend_s1;
	logic [SLOT_W-1:0]               slot_s1;
	logic                            found_q;
	logic [SLOT_W-1:0]               best_slot_q;
	logic signed [WEIGHT_BITS-1:0]   best_w_q;
	logic [NODE_W-1:0]               join_q;
	logic [KIND_W-1:0]               fin_kind_q;

	// derived values
	logic [NCNT_W-1:0]             n_sat;
	logic [ECNT_W-1:0]             m_sat;
	logic                          req_fire;
	logic                          load_fire;
	logic                          start_fire;
	logic                          out_free;
	logic                          rd_issue;
	logic                          scan_end;
	logic                          emit_load;
	logic                          fin_load;

	// edge table read-back
	logic [ENTRY_W-1:0]            wr_entry;
	logic [ENTRY_W-1:0]            rd_entry;
	logic [NODE_W-1:0]             ra;
	logic [NODE_W-1:0]             rb;
	logic signed [WEIGHT_BITS-1:0] rw;
	logic                          cand;
	logic                          take;

	// clamp the counts to what the tables hold
	assign n_sat = (node_cfg_q > NCFG_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES)
		: NCNT_W'(node_cfg_q);
	assign m_sat = (edge_cfg_q > ECFG_W'(MAX_EDGES)) ? ECNT_W'(MAX_EDGES)
		: ECNT_W'(edge_cfg_q);

	assign req_fire   = in_valid && in_ready;
	assign load_fire  = req_fire && (req_type == REQ_LOAD)
		&& (ECNT_W'(edge_slot) < ECNT_W'(MAX_EDGES));
	assign start_fire = req_fire && (req_type == REQ_START);
	assign out_free   = !out_valid || out_ready;

	// edge table: {first end, second end, weight}; the weight is stored in full as a signed 16-bit value
	assign wr_entry = {end_a[NODE_W-1:0], end_b[NODE_W-1:0], edge_weight[WEIGHT_BITS-1:0]};

	pme_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_EDGES)
	) u_edge_ram (
		.clk    (clk),
		.wr_en  (load_fire),
		.wr_addr(edge_slot[SLOT_W-1:0]),
		.wr_data(wr_entry),
		.rd_en  (rd_issue),
		.rd_addr(rd_idx_q[SLOT_W-1:0]),
		.rd_data(rd_entry)
	);

	assign ra = rd_entry[ENTRY_W-1 -: NODE_W];
	assign rb = rd_entry[WEIGHT_BITS +: NODE_W];
	assign rw = rd_entry[WEIGHT_BITS-1:0];

	// shared compare unit: a crossing edge between present nodes, lighter than the best
	// so far; strict less-than keeps the lowest slot on ties
	assign cand = (NCNT_W'(ra) < n_sat) && (NCNT_W'(rb) < n_sat)
		&& (marks_q[ra] != marks_q[rb]);
	assign take = pend_s1 && cand && (!found_q || (rw < best_w_q));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_fire) begin
					if (n_sat == '0 || NCNT_W'(start_node) >= n_sat) begin
						state_nxt = ST_FINISH;
					end else begin
						state_nxt = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_nxt = found_q ? ST_EMIT : ST_FINISH;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		rd_issue  = 1'b0;
		scan_end  = 1'b0;
		emit_load = 1'b0;
		fin_load  = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_SCAN: begin
				rd_issue = (rd_idx_q < m_sat);
				scan_end = (rd_idx_q == m_sat) && !pend_s1;
			end
			ST_EMIT:   emit_load = out_free;
			ST_FINISH: fin_load = out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_cfg_q <= '0;
			edge_cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_NODE_COUNT: node_cfg_q <= cfg_wdata[NCFG_W-1:0];
				REG_EDGE_COUNT: edge_cfg_q <= cfg_wdata[ECFG_W-1:0];
				default: begin
					node_cfg_q <= node_cfg_q;
				end
			endcase
		end
	end

	// sequencer and tree state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			marks_q    <= '0;
			size_q     <= '0;
			total_q    <= '0;
			rd_idx_q   <= '0;
			pend_s1    <= 1'b0;
			found_q    <= 1'b0;
			fin_kind_q <= KIND_DONE;
		end else begin
			state_q <= state_nxt;
			pend_s1 <= rd_issue;

			if (start_fire) begin
				if (n_sat == '0) begin
					fin_kind_q <= KIND_EMPTY;
				end else if (NCNT_W'(start_node) >= n_sat) begin
					fin_kind_q <= KIND_START_MISS;
				end else begin
					// seed the tree with the start node
					marks_q  <= MAX_NODES'(1) << start_node[NODE_W-1:0];
					size_q   <= NCNT_W'(1);
					total_q  <= '0;
					rd_idx_q <= '0;
					found_q  <= 1'b0;
				end
			end

			// advance the scan address
			if (rd_issue) begin
				rd_idx_q <= rd_idx_q + ECNT_W'(1);
			end

			if (take) begin
				found_q <= 1'b1;
			end

			// no crossing edge left: done if every node joined, else disconnected
			if (scan_end && !found_q) begin
				fin_kind_q <= (size_q < n_sat) ? KIND_DISCONNECTED : KIND_DONE;
			end

			// commit the round's winner and restart the scan
			if (emit_load) begin
				marks_q[join_q] <= 1'b1;
				size_q          <= size_q + NCNT_W'(1);
				total_q         <= total_q + TOTAL_W'(best_w_q);
				rd_idx_q        <= '0;
				found_q         <= 1'b0;
			end
		end
	end

	// payload of the running best and the read pipeline
	always_ff @(posedge clk) begin
		slot_s1 <= rd_idx_q[SLOT_W-1:0];
		if (take) begin
			best_slot_q <= slot_s1;
			best_w_q    <= rw;
			join_q      <= marks_q[ra] ? rb : ra;
		end
	end

	// output register: hold a result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit_load || fin_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			kind          <= KIND_EDGE;
			accepted_edge <= 6'(best_slot_q);
			joined_node   <= 5'(join_q);
			total_weight  <= '0;
			last          <= 1'b0;
		end else if (fin_load) begin
			kind          <= fin_kind_q;
			accepted_edge <= '0;
			joined_node   <= '0;
			total_weight  <= (fin_kind_q == KIND_DONE) ? total_q : '0;
			last          <= 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_size_matches_marks: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(marks_q) == 32'(size_q))
		else $error("tree size out of step with tree marks");

	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_SCAN))
		else $error("edge read in flight outside a scan");

	a_emit_has_winner: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (found_q && !marks_q[join_q]))
		else $error("emit without a fresh node to join");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q <= ECNT_W'(MAX_EDGES))
		else $error("scan address past the edge table");
`endif

endmodule

`default_nettype wire
